/* hdl/sscb_pkg.sv */
// Shared types, command constants and the segment table for the
// seven-segment command builder. No dependencies.
package sscb_pkg;

    localparam int QUEUE_DEPTH = 2;

    // One request word as it arrives on the input channel
    typedef struct packed {
        logic              mode;
        logic signed [15:0] value;
        logic [1:0]        position;
        logic [6:0]        digit_code;
    } in_item_t;

    // One result word as it leaves on the output channel
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_before;
        logic       stop_after;
        logic       last;
    } out_item_t;

    // Classified request, passed from the front end to the byte sequencer
    typedef struct packed {
        logic           mode;
        logic [1:0]     position;
        logic [3:0][7:0] seg;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_CONV,
        FE_PUSH
    } fe_state_t;

    localparam logic MODE_INT   = 1'b0;
    localparam logic MODE_DIGIT = 1'b1;

    localparam logic REG_BRIGHTNESS = 1'b0;
    localparam logic REG_DOT_EN     = 1'b1;

    localparam logic [2:0] BRIGHTNESS_RST = 3'd2;
    localparam logic       DOT_EN_RST     = 1'b0;

    localparam logic [7:0] CMD_AUTO_INC   = 8'h40;
    localparam logic [7:0] CMD_FIXED_ADDR = 8'h44;
    localparam logic [7:0] CMD_ADDR_BASE  = 8'hC0;
    localparam logic [7:0] CMD_CTRL_BASE  = 8'h88;
    localparam logic [7:0] SEG_POINT      = 8'h80;

    localparam logic signed [15:0] VALUE_MAX = 16'sd9999;
    localparam logic signed [15:0] VALUE_MIN = -16'sd999;

    localparam int         TABLE_LEN = 18;
    localparam logic [6:0] IDX_MINUS = 7'd16;
    localparam logic [6:0] IDX_BLANK = 7'd17;

    localparam logic [7:0] SEG_TABLE [TABLE_LEN] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h40, 8'h00
    };

    // Digit extraction steps, most significant first
    localparam logic [1:0] STEP_THOUSANDS = 2'd0;
    localparam logic [1:0] STEP_HUNDREDS  = 2'd1;
    localparam logic [1:0] STEP_TENS      = 2'd2;

    // Byte slots within one request
    localparam logic [2:0] SLOT_CMD        = 3'd0;
    localparam logic [2:0] SLOT_ADDR       = 3'd1;
    localparam logic [2:0] SLOT_SEG_FIRST  = 3'd2;
    localparam logic [2:0] SLOT_LAST_INT   = 3'd6;
    localparam logic [2:0] SLOT_LAST_DIGIT = 3'd3;

    // Code one table index; anything past the table is blank
    function automatic logic [7:0] seg_code(input logic [6:0] idx, input logic pt);
        logic [7:0] s;
        if (idx >= 7'(TABLE_LEN)) begin
            s = 8'h00;
        end else begin
            s = SEG_TABLE[idx[4:0]];
        end
        return s | (pt ? SEG_POINT : 8'h00);
    endfunction

    // k times the decimal weight of the given step
    function automatic logic [13:0] step_mult(input logic [1:0] step, input int k);
        logic [13:0] w;
        case (step)
            STEP_THOUSANDS: w = 14'(k * 1000);
            STEP_HUNDREDS:  w = 14'(k * 100);
            default:        w = 14'(k * 10);
        endcase
        return w;
    endfunction

endpackage

/* hdl/sscb_fifo.sv */
// Short command queue between the front end and the byte sequencer.
// Depends on sscb_pkg for the entry and status types.
module sscb_fifo #(
    parameter int DEPTH = sscb_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  sscb_pkg::cmd_t    push_data,
    input  logic              pop,
    output sscb_pkg::cmd_t    head,
    output sscb_pkg::q_stat_t stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    sscb_pkg::cmd_t mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == CW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule

/* hdl/sscb_front.sv */
// Front end: accept requests, range-check, split into decimal digits and
// code the segments. Depends on sscb_pkg.
module sscb_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sscb_pkg::in_item_t s_data,
    input  logic               dot_en,
    input  sscb_pkg::q_stat_t  q_stat,
    output logic               push,
    output sscb_pkg::cmd_t     push_data
);

    sscb_pkg::fe_state_t state_reg, state_next;
    logic [1:0]          step_reg, step_next;
    logic [13:0]         rem_reg, rem_next;
    logic [2:0][3:0]     dig_reg, dig_next;
    logic                neg_reg, neg_next;
    logic                mode_reg, mode_next;
    logic [1:0]          pos_reg, pos_next;
    logic [6:0]          dcode_reg, dcode_next;

    logic        accept;
    logic        in_range;
    logic [15:0] mag;
    logic [3:0]  digit;
    logic [13:0] rem_sub;
    logic [6:0]  idx0, idx1, idx2, idx3;

    assign in_range = (s_data.value <= sscb_pkg::VALUE_MAX)
                   && (s_data.value >= sscb_pkg::VALUE_MIN);
    assign mag      = s_data.value[15] ? 16'(-s_data.value) : 16'(s_data.value);

    // One decimal digit per cycle: compare against the nine multiples of the weight
    always_comb begin
        digit   = '0;
        rem_sub = rem_reg;
        for (int k = 1; k <= 9; k++) begin
            if (rem_reg >= sscb_pkg::step_mult(step_reg, k)) begin
                digit   = 4'(k);
                rem_sub = rem_reg - sscb_pkg::step_mult(step_reg, k);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        dig_next   = dig_reg;
        neg_next   = neg_reg;
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        dcode_next = dcode_reg;
        s_ready    = 1'b0;
        push       = 1'b0;
        accept     = 1'b0;
        case (state_reg)
            sscb_pkg::FE_IDLE: begin
                s_ready = 1'b1;
            end
            sscb_pkg::FE_CONV: begin
                dig_next  = {dig_reg[1:0], digit};
                rem_next  = rem_sub;
                step_next = step_reg + 1'b1;
                if (step_reg == sscb_pkg::STEP_TENS) begin
                    state_next = sscb_pkg::FE_PUSH;
                end
            end
            sscb_pkg::FE_PUSH: begin
                push    = !q_stat.full;
                s_ready = !q_stat.full;
                if (!q_stat.full) begin
                    state_next = sscb_pkg::FE_IDLE;
                end
            end
            default: begin
                state_next = sscb_pkg::FE_IDLE;
            end
        endcase

        accept = s_valid && s_ready;
        if (accept) begin
            mode_next  = s_data.mode;
            pos_next   = s_data.position;
            dcode_next = s_data.digit_code;
            neg_next   = s_data.value[15];
            rem_next   = mag[13:0];
            step_next  = sscb_pkg::STEP_THOUSANDS;
            if (s_data.mode == sscb_pkg::MODE_DIGIT) begin
                state_next = sscb_pkg::FE_PUSH;
            end else if (in_range) begin
                state_next = sscb_pkg::FE_CONV;
            end else begin
                state_next = sscb_pkg::FE_IDLE;
            end
        end
    end

    // Blank leading zeros; the units digit always shows
    always_comb begin
        idx0 = {3'b000, dig_reg[2]};
        idx1 = {3'b000, dig_reg[1]};
        idx2 = {3'b000, dig_reg[0]};
        idx3 = {3'b000, rem_reg[3:0]};
        if (neg_reg) begin
            idx0 = sscb_pkg::IDX_MINUS;
            if (dig_reg[1] == '0) begin
                idx1 = sscb_pkg::IDX_BLANK;
                if (dig_reg[0] == '0) begin
                    idx2 = sscb_pkg::IDX_BLANK;
                end
            end
        end else if (dig_reg[2] == '0) begin
            idx0 = sscb_pkg::IDX_BLANK;
            if (dig_reg[1] == '0) begin
                idx1 = sscb_pkg::IDX_BLANK;
                if (dig_reg[0] == '0) begin
                    idx2 = sscb_pkg::IDX_BLANK;
                end
            end
        end
        if (mode_reg == sscb_pkg::MODE_DIGIT) begin
            idx0 = dcode_reg;
        end
    end

    assign push_data.mode     = mode_reg;
    assign push_data.position = pos_reg;
    assign push_data.seg[0]   = sscb_pkg::seg_code(idx0, dot_en);
    assign push_data.seg[1]   = sscb_pkg::seg_code(idx1, dot_en);
    assign push_data.seg[2]   = sscb_pkg::seg_code(idx2, dot_en);
    assign push_data.seg[3]   = sscb_pkg::seg_code(idx3, dot_en);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sscb_pkg::FE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg  <= step_next;
        rem_reg   <= rem_next;
        dig_reg   <= dig_next;
        neg_reg   <= neg_next;
        mode_reg  <= mode_next;
        pos_reg   <= pos_next;
        dcode_reg <= dcode_next;
    end

endmodule

/* hdl/sscb_back.sv */
// Byte sequencer: walk the queue head one byte per cycle into the output
// register while the output is not stalled. Depends on sscb_pkg.
module sscb_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  sscb_pkg::cmd_t      head,
    input  sscb_pkg::q_stat_t   q_stat,
    output logic                pop,
    input  logic [2:0]          brightness,
    output logic                m_valid,
    input  logic                m_ready,
    output sscb_pkg::out_item_t m_data
);

    logic                m_valid_reg, m_valid_next;
    sscb_pkg::out_item_t m_data_reg, m_data_next;
    logic [2:0]          slot_reg, slot_next;

    logic                load;
    logic [2:0]          last_slot;
    logic                final_slot;
    logic [2:0]          seg_off;
    sscb_pkg::out_item_t word;

    assign load       = !m_valid_reg || m_ready;
    assign last_slot  = (head.mode == sscb_pkg::MODE_DIGIT) ? sscb_pkg::SLOT_LAST_DIGIT
                                                           : sscb_pkg::SLOT_LAST_INT;
    assign final_slot = (slot_reg == last_slot);
    assign seg_off    = slot_reg - sscb_pkg::SLOT_SEG_FIRST;

    always_comb begin
        word.start_before = 1'b0;
        word.stop_after   = 1'b0;
        word.last         = 1'b0;
        if (final_slot) begin
            word.data_byte    = sscb_pkg::CMD_CTRL_BASE + {5'b00000, brightness};
            word.start_before = 1'b1;
            word.stop_after   = 1'b1;
            word.last         = 1'b1;
        end else if (slot_reg == sscb_pkg::SLOT_CMD) begin
            word.data_byte    = (head.mode == sscb_pkg::MODE_DIGIT)
                              ? sscb_pkg::CMD_FIXED_ADDR : sscb_pkg::CMD_AUTO_INC;
            word.start_before = 1'b1;
            word.stop_after   = 1'b1;
        end else if (slot_reg == sscb_pkg::SLOT_ADDR) begin
            word.data_byte    = sscb_pkg::CMD_ADDR_BASE
                              | ((head.mode == sscb_pkg::MODE_DIGIT)
                                 ? {6'b000000, head.position} : 8'h00);
            word.start_before = 1'b1;
        end else begin
            word.data_byte  = head.seg[seg_off[1:0]];
            word.stop_after = (slot_reg == last_slot - 1'b1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        slot_next    = slot_reg;
        pop          = 1'b0;
        if (load) begin
            m_valid_next = !q_stat.empty;
            if (!q_stat.empty) begin
                m_data_next = word;
                if (final_slot) begin
                    slot_next = sscb_pkg::SLOT_CMD;
                    pop       = 1'b1;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            slot_reg    <= sscb_pkg::SLOT_CMD;
        end else begin
            m_valid_reg <= m_valid_next;
            slot_reg    <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* hdl/seven_segment_command_builder.sv */
// An integer request passes a load, three digit steps and a queue write before
// its first byte; a single-digit request skips the digit steps.
// Throughput: one byte per cycle on the output while m_ready is high; an integer
// request makes 7 bytes, a single-digit request 4, one per byte sequencer slot.
// Reset: synchronous, active low; brightness returns to 2, point off, queue empty.
module seven_segment_command_builder #(
    parameter int QUEUE_DEPTH = sscb_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    // request words
    input  logic                s_valid,
    output logic                s_ready,
    input  sscb_pkg::in_item_t  s_data,
    // command byte words
    output logic                m_valid,
    input  logic                m_ready,
    output sscb_pkg::out_item_t m_data,
    // configuration writes
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [2:0]          cfg_wdata
);

    logic [2:0] brightness_reg, brightness_next;
    logic       dot_en_reg, dot_en_next;

    logic              q_push;
    logic              q_pop;
    sscb_pkg::cmd_t    q_push_data;
    sscb_pkg::cmd_t    q_head;
    sscb_pkg::q_stat_t q_stat;

    // Configuration registers: brightness takes the whole write data, the point enable only its low bit
    always_comb begin
        brightness_next = brightness_reg;
        dot_en_next     = dot_en_reg;
        if (cfg_we) begin
            case (cfg_index)
                sscb_pkg::REG_BRIGHTNESS: brightness_next = cfg_wdata;
                sscb_pkg::REG_DOT_EN:     dot_en_next     = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= sscb_pkg::BRIGHTNESS_RST;
            dot_en_reg     <= sscb_pkg::DOT_EN_RST;
        end else begin
            brightness_reg <= brightness_next;
            dot_en_reg     <= dot_en_next;
        end
    end

    // Front end: accept, drop out-of-range integers, split digits, code segments
    sscb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .dot_en    (dot_en_reg),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_data (q_push_data)
    );

    // Hold coded requests so the front end can run ahead of the output
    sscb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // Back end: advance one byte per output word loaded, drop the entry at its end
    sscb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (q_head),
        .q_stat     (q_stat),
        .pop        (q_pop),
        .brightness (brightness_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !q_push)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.empty |-> !q_pop)
        else $error("queue read while empty");

    a_last_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> m_valid && m_data.last)
        else $error("queue entry retired without a final byte");

endmodule
